// ===== rtl/amsa_pkg.sv =====
// shared constants and types for the sample moving average unit
// no dependencies; compiled first
package amsa_pkg;

   // raw register bytes and decoded axis value
   localparam int BYTE_WIDTH = 8;
   localparam int RAW_WIDTH = 10;

   // scaling: value * 10000, then arithmetic shift right by 6
   localparam int SCALE_FACTOR = 10000;
   localparam int PRODUCT_WIDTH = 24;
   localparam int SCALE_SHIFT = 6;
   localparam int SCALED_WIDTH = 18;

   // running sum stays within the range of one scaled sample
   localparam int SUM_WIDTH = 18;

   // calibration offsets and results
   localparam int OFFSET_WIDTH = 19;
   localparam int OUT_WIDTH = 20;

   // ring depth exponent
   localparam int DEPTH_LOG2_DEFAULT = 3;

   // csr register map
   localparam int CSR_INDEX_WIDTH = 2;
   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_SINGLE_SHOT = 2'd0,
      CSR_OFFSET_X    = 2'd1,
      CSR_OFFSET_Y    = 2'd2,
      CSR_OFFSET_Z    = 2'd3
   } csr_index_type;

   // per-request control handed to every axis lane
   typedef struct packed {
      logic load;
      logic clear;
      logic single_shot;
   } lane_ctl_type;

   // one result held in the output stage
   typedef struct packed {
      logic signed [OUT_WIDTH-1:0] x;
      logic signed [OUT_WIDTH-1:0] y;
      logic signed [OUT_WIDTH-1:0] z;
   } rsp_data_type;

endpackage

// ===== rtl/amsa_req_if.sv =====
// request channel: clear flag and six raw sensor register bytes
// depends on amsa_pkg
interface amsa_req_if;
   import amsa_pkg::*;

   logic                  valid;
   logic                  ready;
   logic                  mode;
   logic [BYTE_WIDTH-1:0] y_low_byte;
   logic [BYTE_WIDTH-1:0] y_high_byte;
   logic [BYTE_WIDTH-1:0] x_low_byte;
   logic [BYTE_WIDTH-1:0] x_high_byte;
   logic [BYTE_WIDTH-1:0] z_low_byte;
   logic [BYTE_WIDTH-1:0] z_high_byte;

   modport source (
      output valid, mode, y_low_byte, y_high_byte, x_low_byte, x_high_byte,
             z_low_byte, z_high_byte,
      input  ready
   );

   modport sink (
      input  valid, mode, y_low_byte, y_high_byte, x_low_byte, x_high_byte,
             z_low_byte, z_high_byte,
      output ready
   );

endinterface

// ===== rtl/amsa_rsp_if.sv =====
// response channel: filtered three-axis result
// depends on amsa_pkg
interface amsa_rsp_if;
   import amsa_pkg::*;

   logic                        valid;
   logic                        ready;
   logic signed [OUT_WIDTH-1:0] out_x;
   logic signed [OUT_WIDTH-1:0] out_y;
   logic signed [OUT_WIDTH-1:0] out_z;

   modport source (
      output valid, out_x, out_y, out_z,
      input  ready
   );

   modport sink (
      input  valid, out_x, out_y, out_z,
      output ready
   );

endinterface

// ===== rtl/amsa_csr_if.sv =====
// csr write channel: register index and write data
// depends on amsa_pkg
interface amsa_csr_if;
   import amsa_pkg::*;

   logic                       valid;
   logic                       ready;
   logic [CSR_INDEX_WIDTH-1:0] index;
   logic [OFFSET_WIDTH-1:0]    data;

   modport source (
      output valid, index, data,
      input  ready
   );

   modport sink (
      input  valid, index, data,
      output ready
   );

endinterface

// ===== rtl/amsa_lane.sv =====
// one axis lane: decode, scale, sample shift line and running sum
// depends on amsa_pkg
module amsa_lane #(
   parameter int DEPTH_LOG2 = amsa_pkg::DEPTH_LOG2_DEFAULT
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  amsa_pkg::lane_ctl_type                  ctl,
   input  logic [amsa_pkg::BYTE_WIDTH-1:0]         low_byte,
   input  logic [amsa_pkg::BYTE_WIDTH-1:0]         high_byte,
   output logic signed [amsa_pkg::SUM_WIDTH-1:0]   sum_next
);
   import amsa_pkg::*;

   localparam int DEPTH = 1 << DEPTH_LOG2;
   localparam int ENTRY_WIDTH = SCALED_WIDTH - DEPTH_LOG2;

   logic signed [RAW_WIDTH-1:0]     raw;
   logic signed [PRODUCT_WIDTH-1:0] product;
   logic signed [SCALED_WIDTH-1:0]  scaled;
   logic signed [ENTRY_WIDTH-1:0]   shifted;
   logic signed [SUM_WIDTH-1:0]     step_sum;
   logic signed [SUM_WIDTH-1:0]     fill_sum;
   logic signed [ENTRY_WIDTH-1:0]   taps_ff [DEPTH];
   logic signed [ENTRY_WIDTH-1:0]   taps_in [DEPTH];
   logic signed [SUM_WIDTH-1:0]     sum_ff;
   logic signed [SUM_WIDTH-1:0]     sum_in;

   // high byte is bits 9..2, top two bits of low byte are bits 1..0
   assign raw = {high_byte, low_byte[BYTE_WIDTH-1 -: 2]};

   // scale, floor divide by 64, then pre-shift by the ring depth
   assign product = PRODUCT_WIDTH'(raw) * PRODUCT_WIDTH'(SCALE_FACTOR);
   assign scaled  = product[SCALE_SHIFT +: SCALED_WIDTH];
   assign shifted = scaled[SCALED_WIDTH-1:DEPTH_LOG2];

   // running sum: oldest tap leaves, new entry comes in
   assign step_sum = sum_ff - SUM_WIDTH'(taps_ff[DEPTH-1]) + SUM_WIDTH'(shifted);
   // every tap holds the new entry
   assign fill_sum = SUM_WIDTH'(shifted) <<< DEPTH_LOG2;

   // next state of the shift line and sum
   always_comb begin
      taps_in = taps_ff;
      sum_in  = sum_ff;
      if (ctl.load) begin
         priority if (ctl.clear) begin
            for (int i = 0; i < DEPTH; i++) taps_in[i] = '0;
            sum_in = '0;
         end else if (ctl.single_shot) begin
            for (int i = 0; i < DEPTH; i++) taps_in[i] = shifted;
            sum_in = fill_sum;
         end else begin
            taps_in[0] = shifted;
            for (int i = 1; i < DEPTH; i++) taps_in[i] = taps_ff[i-1];
            sum_in = step_sum;
         end
      end
   end

   assign sum_next = sum_in;

   // shift line and sum registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DEPTH; i++) taps_ff[i] <= '0;
         sum_ff <= '0;
      end else begin
         taps_ff <= taps_in;
         sum_ff  <= sum_in;
      end
   end

endmodule

// ===== rtl/amsa_merge.sv =====
// merge stage: applies offsets and Y negation, holds results in an
// output register with a skid entry; depends on amsa_pkg and amsa_rsp_if
module amsa_merge (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     emit,
   input  logic signed [amsa_pkg::SUM_WIDTH-1:0]    sum_x,
   input  logic signed [amsa_pkg::SUM_WIDTH-1:0]    sum_y,
   input  logic signed [amsa_pkg::SUM_WIDTH-1:0]    sum_z,
   input  logic signed [amsa_pkg::OFFSET_WIDTH-1:0] offset_x,
   input  logic signed [amsa_pkg::OFFSET_WIDTH-1:0] offset_y,
   input  logic signed [amsa_pkg::OFFSET_WIDTH-1:0] offset_z,
   output logic                                     room,
   amsa_rsp_if.source                               rsp_chan
);
   import amsa_pkg::*;

   rsp_data_type result;
   rsp_data_type out_data_ff;
   rsp_data_type out_data_in;
   rsp_data_type skid_data_ff;
   rsp_data_type skid_data_in;
   logic         out_valid_ff;
   logic         out_valid_in;
   logic         skid_valid_ff;
   logic         skid_valid_in;
   logic         out_take;

   // combine lane sums with calibration offsets
   always_comb begin
      result.x = OUT_WIDTH'(sum_x) - OUT_WIDTH'(offset_x);
      result.y = OUT_WIDTH'(0) - OUT_WIDTH'(sum_y) - OUT_WIDTH'(offset_y);
      result.z = OUT_WIDTH'(sum_z) - OUT_WIDTH'(offset_z);
   end

   assign out_take = out_valid_ff && rsp_chan.ready;
   assign room     = !skid_valid_ff;

   // output register and skid entry
   always_comb begin
      out_data_in   = out_data_ff;
      out_valid_in  = out_valid_ff;
      skid_data_in  = skid_data_ff;
      skid_valid_in = skid_valid_ff;
      if (skid_valid_ff) begin
         if (out_take) begin
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end
      end else if (emit) begin
         if (!out_valid_ff || out_take) begin
            out_data_in  = result;
            out_valid_in = 1'b1;
         end else begin
            skid_data_in  = result;
            skid_valid_in = 1'b1;
         end
      end else if (out_take) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   // response ports
   assign rsp_chan.valid = out_valid_ff;
   assign rsp_chan.out_x = out_data_ff.x;
   assign rsp_chan.out_y = out_data_ff.y;
   assign rsp_chan.out_z = out_data_ff.z;

endmodule

// ===== rtl/accel_sample_moving_average_unit.sv =====
// top level of the three-axis sample moving average unit
// depends on amsa_pkg, the channel interfaces, amsa_lane and amsa_merge

// Three axis lanes each decode a 10-bit signed value from two register bytes,
// scale it by 10000/64 and keep a shift line of 2**DEPTH_LOG2 entries, already
// shifted right by DEPTH_LOG2, with a running sum beside it. A request is
// taken every clock cycle while the skid entry is free; a result, if any, goes
// to the output register, or to the skid entry if that one holds an untaken result.
// Each lane update is one constant multiply and one add/subtract on the running
// sum per request. Results appear once 2**DEPTH_LOG2 samples are taken since
// reset or the last clear request; in single-shot mode every sample fills the
// whole line and gives a result at once. A clear request (mode = 1) empties
// the lines and gives no result. An output register plus one skid entry let
// requests keep flowing while a result waits to be taken. CSR writes are
// always accepted and must be made while the unit is idle.
module accel_sample_moving_average_unit #(
   parameter int DEPTH_LOG2 = amsa_pkg::DEPTH_LOG2_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   amsa_req_if.sink    req_chan,
   amsa_rsp_if.source  rsp_chan,
   amsa_csr_if.sink    csr_chan
);
   import amsa_pkg::*;

   localparam int FILL_WIDTH = DEPTH_LOG2 + 1;
   localparam logic [FILL_WIDTH-1:0] FILL_FULL = FILL_WIDTH'(1 << DEPTH_LOG2);

   logic                           single_shot_ff;
   logic                           single_shot_in;
   logic signed [OFFSET_WIDTH-1:0] offset_x_ff;
   logic signed [OFFSET_WIDTH-1:0] offset_x_in;
   logic signed [OFFSET_WIDTH-1:0] offset_y_ff;
   logic signed [OFFSET_WIDTH-1:0] offset_y_in;
   logic signed [OFFSET_WIDTH-1:0] offset_z_ff;
   logic signed [OFFSET_WIDTH-1:0] offset_z_in;
   logic [FILL_WIDTH-1:0]          fill_ff;
   logic [FILL_WIDTH-1:0]          fill_in;
   logic                           accept;
   logic                           emit;
   logic                           room;
   lane_ctl_type                   ctl;
   logic signed [SUM_WIDTH-1:0]    sum_x;
   logic signed [SUM_WIDTH-1:0]    sum_y;
   logic signed [SUM_WIDTH-1:0]    sum_z;

   // csr writes
   assign csr_chan.ready = 1'b1;

   always_comb begin
      single_shot_in = single_shot_ff;
      offset_x_in    = offset_x_ff;
      offset_y_in    = offset_y_ff;
      offset_z_in    = offset_z_ff;
      if (csr_chan.valid) begin
         unique case (csr_index_type'(csr_chan.index))
            CSR_SINGLE_SHOT: single_shot_in = csr_chan.data[0];
            CSR_OFFSET_X:    offset_x_in    = csr_chan.data;
            CSR_OFFSET_Y:    offset_y_in    = csr_chan.data;
            CSR_OFFSET_Z:    offset_z_in    = csr_chan.data;
            default:         single_shot_in = single_shot_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         single_shot_ff <= 1'b0;
         offset_x_ff    <= '0;
         offset_y_ff    <= '0;
         offset_z_ff    <= '0;
      end else begin
         single_shot_ff <= single_shot_in;
         offset_x_ff    <= offset_x_in;
         offset_y_ff    <= offset_y_in;
         offset_z_ff    <= offset_z_in;
      end
   end

   // request handshake and lane control
   assign req_chan.ready  = room;
   assign accept          = req_chan.valid && room;
   assign ctl.load        = accept;
   assign ctl.clear       = req_chan.mode;
   assign ctl.single_shot = single_shot_ff;

   // warm-up count, saturating at the ring depth
   always_comb begin
      fill_in = fill_ff;
      if (accept) begin
         priority if (req_chan.mode) begin
            fill_in = '0;
         end else if (single_shot_ff) begin
            fill_in = FILL_FULL;
         end else if (fill_ff != FILL_FULL) begin
            fill_in = fill_ff + FILL_WIDTH'(1);
         end else begin
            fill_in = fill_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else begin
         fill_ff <= fill_in;
      end
   end

   assign emit = accept && !req_chan.mode && (fill_in == FILL_FULL);

   // one lane per axis
   amsa_lane #(.DEPTH_LOG2(DEPTH_LOG2)) u_lane_x (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ctl),
      .low_byte  (req_chan.x_low_byte),
      .high_byte (req_chan.x_high_byte),
      .sum_next  (sum_x)
   );

   amsa_lane #(.DEPTH_LOG2(DEPTH_LOG2)) u_lane_y (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ctl),
      .low_byte  (req_chan.y_low_byte),
      .high_byte (req_chan.y_high_byte),
      .sum_next  (sum_y)
   );

   amsa_lane #(.DEPTH_LOG2(DEPTH_LOG2)) u_lane_z (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ctl),
      .low_byte  (req_chan.z_low_byte),
      .high_byte (req_chan.z_high_byte),
      .sum_next  (sum_z)
   );

   // offsets, Y negation and output buffering
   amsa_merge u_merge (
      .clock    (clock),
      .reset    (reset),
      .emit     (emit),
      .sum_x    (sum_x),
      .sum_y    (sum_y),
      .sum_z    (sum_z),
      .offset_x (offset_x_ff),
      .offset_y (offset_y_ff),
      .offset_z (offset_z_ff),
      .room     (room),
      .rsp_chan (rsp_chan)
   );

endmodule
